// ===== rtl/gps_pkg.sv =====
// Shared types, register codes and helper functions for the grid path sum block.
package gps_pkg;

  localparam int DEF_MAX_COLS = 512;
  localparam int DEF_MAX_ROWS = 512;

  localparam int DIM_REG_W = 10;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef logic signed [15:0] cell_t;
  typedef logic signed [31:0] sum_t;

  typedef struct packed {
    sum_t l2;
    sum_t l1;
    sum_t l0;
  } levels_t;

  typedef struct packed {
    logic has_up;
    logic has_left;
  } nbr_ctrl_t;

  typedef struct packed {
    logic clamped;
    sum_t value;
  } sat_sum_t;

  typedef struct packed {
    sum_t best_amount;
    logic saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_REG_W-1:0] value;
  } cfg_wr_t;

  // Clamps a wide intermediate sum into the signed 32-bit range.
  function automatic sat_sum_t clamp_sum(logic signed [33:0] x);
    sat_sum_t r;
    if (x > 34'sh0_7FFF_FFFF) begin
      r.clamped = 1'b1;
      r.value   = 32'sh7FFF_FFFF;
    end else if (x < -34'sh0_8000_0000) begin
      r.clamped = 1'b1;
      r.value   = 32'sh8000_0000;
    end else begin
      r.clamped = 1'b0;
      r.value   = x[31:0];
    end
    return r;
  endfunction

  // A zero register counts as one, a value above the limit as the limit.
  function automatic int eff_dim(logic [DIM_REG_W-1:0] r, int maxv);
    int res;
    if (r == '0) begin
      res = 1;
    end else if (int'(r) > maxv) begin
      res = maxv;
    end else begin
      res = int'(r);
    end
    return res;
  endfunction

endpackage

// ===== rtl/gps_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
interface gps_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/gps_row_mem.sv =====
// Previous-row buffer holding the three level sums of each column.
module gps_row_mem
  import gps_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [COL_W-1:0] waddr_i,
  input  levels_t          wdata_i,
  input  logic             re_i,
  input  logic [COL_W-1:0] raddr_i,
  output levels_t          rdata_o
);

  levels_t mem [MAX_COLS];
  levels_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gps_cell_unit.sv =====
// Per-cell update of the three skip levels from the up and left neighbors.
module gps_cell_unit
  import gps_pkg::*;
(
  input  cell_t     value_i,
  input  nbr_ctrl_t ctrl_i,
  input  levels_t   up_i,
  input  levels_t   left_i,
  output levels_t   next_o,
  output logic      sat_o
);

  levels_t            p;
  logic signed [33:0] v_x;
  logic signed [33:0] s0;
  logic signed [33:0] a1;
  logic signed [33:0] a2;
  logic signed [33:0] m1;
  logic signed [33:0] m2;
  sat_sum_t           c0;
  sat_sum_t           c1;
  sat_sum_t           c2;

  always_comb begin
    if (ctrl_i.has_up && ctrl_i.has_left) begin
      p.l0 = (up_i.l0 > left_i.l0) ? up_i.l0 : left_i.l0;
      p.l1 = (up_i.l1 > left_i.l1) ? up_i.l1 : left_i.l1;
      p.l2 = (up_i.l2 > left_i.l2) ? up_i.l2 : left_i.l2;
    end else if (ctrl_i.has_up) begin
      p = up_i;
    end else begin
      p = left_i;
    end
  end

  assign v_x = 34'(value_i);
  assign s0  = 34'(p.l0) + v_x;
  assign a1  = 34'(p.l1) + v_x;
  assign a2  = 34'(p.l2) + v_x;
  assign m1  = (34'(p.l0) > a1) ? 34'(p.l0) : a1;
  assign m2  = (34'(p.l1) > a2) ? 34'(p.l1) : a2;
  assign c0  = clamp_sum(s0);
  assign c1  = clamp_sum(m1);
  assign c2  = clamp_sum(m2);

  always_comb begin
    if (!ctrl_i.has_up && !ctrl_i.has_left) begin
      // The first cell of the grid starts every level without any neighbor.
      next_o.l0 = 32'(value_i);
      next_o.l1 = value_i[15] ? '0 : 32'(value_i);
      next_o.l2 = value_i[15] ? '0 : 32'(value_i);
      sat_o     = 1'b0;
    end else begin
      next_o.l0 = c0.value;
      next_o.l1 = c1.value;
      next_o.l2 = c2.value;
      sat_o     = c0.clamped | c1.clamped | c2.clamped;
    end
  end

endmodule

// ===== rtl/grid_path_sum_with_skips.sv =====
// Top level: raster-order grid path sum with up to two skipped cells.
// Throughput: one cell per cycle while no last cell stalls; a cell and its row buffer word
// are registered at acceptance, and the update from these registers loads the left register
// and, for a last cell, the output register. Only a last cell can stall, while the previous
// result still waits. Reset: position, left sums, saturation flag and output valid clear at
// once; dimensions reset to one, buffers not.
module grid_path_sum_with_skips
  import gps_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gps_stream_if.sink   cfg_ch,
  gps_stream_if.sink   in_ch,
  gps_stream_if.source out_ch
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [DIM_REG_W-1:0] rows_cfg_q;
  logic [DIM_REG_W-1:0] cols_cfg_q;
  logic [COL_W-1:0]     col_q;
  logic [ROW_W-1:0]     row_q;
  int                   rows_eff;
  int                   cols_eff;
  logic                 col_last;
  logic                 row_last;
  logic                 cols_one;

  logic                 cfg_fire;
  logic                 cfg_hit;
  logic                 in_fire;
  logic                 in_ready;
  logic                 proc_fire;

  logic                 valid_q;
  cell_t                cell_q;
  nbr_ctrl_t            ctrl_q;
  logic [COL_W-1:0]     c_q;
  logic                 last_q;

  levels_t              left_q;
  logic                 sat_q;
  levels_t              up_rd;
  levels_t              up_sel;
  levels_t              next_lv;
  logic                 cell_sat;

  logic                 out_valid_q;
  result_t              out_data_q;

  assign rows_eff = eff_dim(rows_cfg_q, MAX_ROWS);
  assign cols_eff = eff_dim(cols_cfg_q, MAX_COLS);
  assign col_last = (col_q == COL_W'(cols_eff - 1));
  assign row_last = (row_q == ROW_W'(rows_eff - 1));
  assign cols_one = (cols_eff == 1);

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign cfg_hit      = cfg_fire &&
                        ((cfg_ch.data.index == REG_GRID_ROWS) ||
                         (cfg_ch.data.index == REG_GRID_COLS));

  // Only a last cell can wait on a full output register.
  assign proc_fire   = valid_q && (!last_q || !out_valid_q || out_ch.ready);
  assign in_ready    = !valid_q || proc_fire;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DIM_REG_W'(1);
      cols_cfg_q <= DIM_REG_W'(1);
    end else if (cfg_fire) begin
      unique case (cfg_ch.data.index)
        REG_GRID_ROWS: rows_cfg_q <= cfg_ch.data.value;
        REG_GRID_COLS: cols_cfg_q <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_fire) begin
      valid_q <= 1'b1;
    end else if (proc_fire) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cell_q          <= in_ch.data;
      c_q             <= col_q;
      ctrl_q.has_up   <= (row_q != '0);
      ctrl_q.has_left <= (col_q != '0);
      last_q          <= col_last && row_last;
    end
  end

  gps_row_mem #(
    .MAX_COLS(MAX_COLS)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (proc_fire),
    .waddr_i (c_q),
    .wdata_i (next_lv),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  // With a single column the cell above is the previous cell, still in the left register.
  assign up_sel = cols_one ? left_q : up_rd;

  gps_cell_unit u_cell_unit (
    .value_i (cell_q),
    .ctrl_i  (ctrl_q),
    .up_i    (up_sel),
    .left_i  (left_q),
    .next_o  (next_lv),
    .sat_o   (cell_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      sat_q  <= 1'b0;
    end else if (cfg_hit) begin
      left_q <= '0;
      sat_q  <= 1'b0;
    end else if (proc_fire) begin
      left_q <= next_lv;
      sat_q  <= last_q ? 1'b0 : (sat_q | cell_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && last_q) begin
      out_data_q.best_amount <= next_lv.l2;
      out_data_q.saturated   <= sat_q | cell_sat;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

`ifndef SYNTHESIS
  a_stall_holds_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !proc_fire) |=> (valid_q && $stable(c_q) && $stable(cell_q)))
    else $error("stalled cell changed in the input register");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_fire && last_q))
    else $error("result appeared without a last cell");

  a_left_not_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ctrl_q.has_left) |-> (c_q != '0))
    else $error("left neighbor flagged in column zero");

  a_ready_only_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (valid_q && last_q && out_valid_q && !out_ch.ready))
    else $error("input blocked without a waiting result");
`endif

endmodule
